@@ hw/rtl/tsps_pkg.sv @@
// Shared constants, codes and types of the song position sequencer.
package tsps_pkg;

  localparam int unsigned ORDER_DEPTH      = 128;
  localparam int unsigned ROWS_PER_PATTERN = 64;
  localparam int unsigned DEFAULT_SPEED    = 6;

  localparam int unsigned ORDER_AW = (ORDER_DEPTH > 1) ? $clog2(ORDER_DEPTH) : 1;

  localparam logic [8:0] ORDER_LIMIT = 9'(ORDER_DEPTH);
  localparam logic [8:0] ROWS_LIMIT  = 9'(ROWS_PER_PATTERN);
  localparam logic [4:0] SPEED_RESET = 5'(DEFAULT_SPEED);

  localparam logic [7:0] FINE_THRESHOLD = 8'd32;
  localparam logic [7:0] FINE_DEFAULT   = 8'd100;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_LOAD    = 2'd1,
    OP_RESTART = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_ENDED = 2'd1,
    ST_FATAL = 2'd2
  } status_e;

  typedef enum logic {
    CFG_SONG_LENGTH   = 1'b0,
    CFG_PATTERN_COUNT = 1'b1
  } cfg_reg_e;

endpackage

@@ hw/rtl/tsps_if.sv @@
// Channel interfaces of the song position sequencer: items, results and configuration.
interface tsps_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [6:0] order_index;
  logic [6:0] order_value;
  logic       speed_request;
  logic [7:0] speed_value;
  logic       skip_request;
  logic [5:0] skip_row;
  logic       jump_request;
  logic [6:0] jump_position;

  modport source (
    output valid, opcode, order_index, order_value, speed_request, speed_value,
           skip_request, skip_row, jump_request, jump_position,
    input  ready
  );
  modport sink (
    input  valid, opcode, order_index, order_value, speed_request, speed_value,
           skip_request, skip_row, jump_request, jump_position,
    output ready
  );
endinterface

interface tsps_result_if;
  logic       valid;
  logic       ready;
  logic [6:0] order_position;
  logic [6:0] pattern_number;
  logic [5:0] row;
  logic [4:0] tick_count;
  logic [4:0] speed;
  logic [7:0] fine_speed;
  logic       row_advanced;
  logic [1:0] status;

  modport source (
    output valid, order_position, pattern_number, row, tick_count, speed, fine_speed,
           row_advanced, status,
    input  ready
  );
  modport sink (
    input  valid, order_position, pattern_number, row, tick_count, speed, fine_speed,
           row_advanced, status,
    output ready
  );
endinterface

interface tsps_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [7:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

@@ hw/rtl/tsps_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module tsps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/tracker_song_position_sequencer.sv @@
// Song position sequencer: order position, pattern, row, tick and speed of tracker playback.
// The block takes one transaction per clock cycle when the output is not stalled and
// delivers one result for every transaction: the accepting cycle updates position, row,
// tick and speed and starts the order table read; the stage after it checks the pattern
// number read from the order table memory and sets the status on its way to the output
// register, which decouples the result side, so a new transaction is taken while a finished
// result waits. The order table holds no defined contents after reset and must be loaded
// before playback reaches an entry; there is no clearing pass. Configuration writes are
// taken in every cycle and are meant to happen only while the block is idle.
module tracker_song_position_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  tsps_item_if.sink          in_i,
  tsps_result_if.source      out_o,
  tsps_cfg_if.sink           cfg_i
);
  import tsps_pkg::*;

  logic [7:0] song_length_q, pattern_count_q;

  logic [7:0] position_q, position_d;
  logic [5:0] row_q, row_d;
  logic [4:0] tick_q, tick_d;
  logic [4:0] speed_q, speed_d;
  logic [7:0] fine_q, fine_d;
  logic       pend_skip_q, pend_skip_d;
  logic [5:0] pend_row_q, pend_row_d;
  logic       pend_jump_q, pend_jump_d;
  logic [6:0] pend_pos_q, pend_pos_d;

  logic [6:0] pattern_q, pattern_d;
  status_e    status_q, status_d;

  logic s1_valid_q, s1_select_q, s1_restart_q, s1_ended_q, s1_bad_q, s1_oob_q, s1_adv_q;
  logic select_d, restart_d, ended_d, bad_d, oob_d, adv_d;

  logic       out_valid_q;
  logic [6:0] out_position_q, out_pattern_q;
  logic [5:0] out_row_q;
  logic [4:0] out_tick_q, out_speed_q;
  logic [7:0] out_fine_q;
  logic       out_adv_q;
  status_e    out_status_q;

  logic       in_fire, s1_move;
  logic       ram_we;
  logic [7:0] widx;
  logic [7:0] ridx;
  logic [6:0] rdata;

  logic [5:0] tick_sum;
  logic [8:0] row_sum;
  logic [7:0] next_pos;
  logic       jump_now, skip_now;
  logic [6:0] jump_pos_now;
  logic [5:0] skip_row_now;
  logic [6:0] pat;
  logic       fatal;
  status_e    status_base;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      song_length_q   <= 8'd1;
      pattern_count_q <= 8'd1;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_SONG_LENGTH:   song_length_q   <= cfg_i.data;
        CFG_PATTERN_COUNT: pattern_count_q <= cfg_i.data;
        default:           song_length_q   <= song_length_q;
      endcase
    end
  end

  assign s1_move    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_move;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    position_d  = position_q;
    row_d       = row_q;
    tick_d      = tick_q;
    speed_d     = speed_q;
    fine_d      = fine_q;
    pend_skip_d = pend_skip_q;
    pend_row_d  = pend_row_q;
    pend_jump_d = pend_jump_q;
    pend_pos_d  = pend_pos_q;
    select_d    = 1'b0;
    restart_d   = 1'b0;
    ended_d     = 1'b0;
    adv_d       = 1'b0;
    ram_we      = 1'b0;
    tick_sum    = 6'd0;
    row_sum     = 9'd0;
    next_pos    = 8'd0;

    jump_now     = pend_jump_q || in_i.jump_request;
    jump_pos_now = in_i.jump_request ? in_i.jump_position : pend_pos_q;
    skip_now     = pend_skip_q || in_i.skip_request;
    skip_row_now = in_i.skip_request ? in_i.skip_row : pend_row_q;

    case (opcode_e'(in_i.opcode))
      OP_LOAD: begin
        ram_we = ({1'b0, widx} < ORDER_LIMIT);
      end
      OP_RESTART: begin
        position_d  = 8'd0;
        row_d       = 6'd0;
        tick_d      = 5'd0;
        speed_d     = SPEED_RESET;
        fine_d      = FINE_DEFAULT;
        pend_skip_d = 1'b0;
        pend_row_d  = 6'd0;
        pend_jump_d = 1'b0;
        pend_pos_d  = 7'd0;
        restart_d   = 1'b1;
        select_d    = 1'b1;
      end
      OP_TICK: begin
        pend_skip_d = skip_now;
        pend_row_d  = skip_row_now;
        pend_jump_d = jump_now;
        pend_pos_d  = jump_pos_now;
        if (in_i.speed_request && (in_i.speed_value != 8'd0)) begin
          if (in_i.speed_value >= FINE_THRESHOLD) begin
            fine_d = in_i.speed_value;
          end else begin
            speed_d = in_i.speed_value[4:0];
            fine_d  = FINE_DEFAULT;
          end
        end
        tick_sum = {1'b0, tick_q} + 6'd1;
        tick_d   = tick_sum[4:0];
        if (tick_sum >= {1'b0, speed_d}) begin
          tick_d      = 5'd0;
          adv_d       = 1'b1;
          pend_skip_d = 1'b0;
          pend_jump_d = 1'b0;
          next_pos    = position_q + 8'd1;
          if (jump_now) begin
            position_d = {1'b0, jump_pos_now};
            select_d   = 1'b1;
            row_d      = 6'd0;
          end else begin
            row_sum = {3'b000, row_q} + 9'd1;
            if (skip_now || (row_sum >= ROWS_LIMIT)) begin
              if (next_pos >= song_length_q) begin
                position_d = 8'd0;
                ended_d    = 1'b1;
              end else begin
                position_d = next_pos;
              end
              select_d = 1'b1;
              row_d    = skip_now ? skip_row_now : 6'd0;
            end else begin
              row_d = row_sum[5:0];
            end
          end
        end
      end
      default: begin
        position_d = position_q;
      end
    endcase
  end

  assign widx  = {1'b0, in_i.order_index};
  assign ridx  = position_d;
  assign bad_d = (position_d >= song_length_q);
  assign oob_d = ({1'b0, ridx} >= ORDER_LIMIT);

  tsps_ram #(
    .WIDTH (7),
    .DEPTH (ORDER_DEPTH)
  ) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && ram_we),
    .waddr_i (widx[ORDER_AW-1:0]),
    .wdata_i (in_i.order_value),
    .re_i    (in_fire),
    .raddr_i (ridx[ORDER_AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q  <= 8'd0;
      row_q       <= 6'd0;
      tick_q      <= 5'd0;
      speed_q     <= SPEED_RESET;
      fine_q      <= FINE_DEFAULT;
      pend_skip_q <= 1'b0;
      pend_row_q  <= 6'd0;
      pend_jump_q <= 1'b0;
      pend_pos_q  <= 7'd0;
      s1_valid_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        position_q  <= position_d;
        row_q       <= row_d;
        tick_q      <= tick_d;
        speed_q     <= speed_d;
        fine_q      <= fine_d;
        pend_skip_q <= pend_skip_d;
        pend_row_q  <= pend_row_d;
        pend_jump_q <= pend_jump_d;
        pend_pos_q  <= pend_pos_d;
        s1_valid_q  <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_select_q  <= select_d;
      s1_restart_q <= restart_d;
      s1_ended_q   <= ended_d;
      s1_bad_q     <= bad_d;
      s1_oob_q     <= oob_d;
      s1_adv_q     <= adv_d;
    end
  end

  always_comb begin
    pat         = s1_oob_q ? 7'd0 : rdata;
    fatal       = s1_bad_q || ({1'b0, pat} >= pattern_count_q);
    status_base = s1_restart_q ? ST_NONE : status_q;
    pattern_d   = pattern_q;
    status_d    = status_base;
    if (s1_ended_q && (status_base != ST_FATAL)) begin
      status_d = ST_ENDED;
    end
    if (s1_select_q) begin
      if (fatal) begin
        status_d = ST_FATAL;
      end else begin
        pattern_d = pat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q   <= 7'd0;
      status_q    <= ST_NONE;
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      pattern_q   <= pattern_d;
      status_q    <= status_d;
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_position_q <= position_q[6:0];
      out_pattern_q  <= pattern_d;
      out_row_q      <= row_q;
      out_tick_q     <= tick_q;
      out_speed_q    <= speed_q;
      out_fine_q     <= fine_q;
      out_adv_q      <= s1_adv_q;
      out_status_q   <= status_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.order_position = out_position_q;
  assign out_o.pattern_number = out_pattern_q;
  assign out_o.row            = out_row_q;
  assign out_o.tick_count     = out_tick_q;
  assign out_o.speed          = out_speed_q;
  assign out_o.fine_speed     = out_fine_q;
  assign out_o.row_advanced   = out_adv_q;
  assign out_o.status         = out_status_q;

endmodule

@@ hw/rtl/tsps_checker.sv @@
// Port-level assertions of the song position sequencer and their bind statement.
module tsps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [6:0] order_position_i,
  input logic [6:0] pattern_number_i,
  input logic [5:0] row_i,
  input logic [4:0] tick_count_i,
  input logic [4:0] speed_i,
  input logic [7:0] fine_speed_i,
  input logic       row_advanced_i,
  input logic [1:0] status_i
);
  import tsps_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({order_position_i, pattern_number_i, row_i, tick_count_i, speed_i,
               fine_speed_i, row_advanced_i, status_i}))
    else $error("Stalled result transaction changed.");

  a_adv_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && row_advanced_i |-> tick_count_i == 5'd0)
    else $error("Row advanced without clearing the tick count.");

  a_tick_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> tick_count_i < speed_i)
    else $error("Tick count not below ticks per row.");

  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> fine_speed_i >= FINE_THRESHOLD && status_i != 2'd3)
    else $error("Fine speed or status out of range.");

endmodule

bind tracker_song_position_sequencer tsps_checker u_tsps_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .order_position_i (out_o.order_position),
  .pattern_number_i (out_o.pattern_number),
  .row_i            (out_o.row),
  .tick_count_i     (out_o.tick_count),
  .speed_i          (out_o.speed),
  .fine_speed_i     (out_o.fine_speed),
  .row_advanced_i   (out_o.row_advanced),
  .status_i         (out_o.status)
);
